@@ rtl/assert_macros.svh @@
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset, on the clk and rst of the user
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/vp9pk_pkg.sv @@
// shared types and constants of the vp9 rtp payload packetizer
package vp9pk_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [13:0] MAX_FRAG_RESET = 14'd1200;
  localparam logic [13:0] MIN_FRAG       = 14'd9;
  localparam logic [13:0] HDR_BASIC_LEN  = 14'd3;
  localparam logic [13:0] HDR_SS_LEN     = 14'd8;

  // payload descriptor bits
  localparam logic [7:0] DESC_I   = 8'h80;
  localparam logic [7:0] DESC_P   = 8'h40;
  localparam logic [7:0] DESC_B   = 8'h08;
  localparam logic [7:0] DESC_E   = 8'h04;
  localparam logic [7:0] DESC_V   = 8'h02;
  localparam logic [7:0] PICID_M  = 8'h80;
  localparam logic [7:0] SS_BYTE0 = 8'h10;

  // byte positions within one fragment command
  localparam logic [3:0] POS_DESC   = 4'd0;
  localparam logic [3:0] POS_PIC_HI = 4'd1;
  localparam logic [3:0] POS_PIC_LO = 4'd2;
  localparam logic [3:0] POS_SS     = 4'd3;
  localparam logic [3:0] POS_W_HI   = 4'd4;
  localparam logic [3:0] POS_W_LO   = 4'd5;
  localparam logic [3:0] POS_H_HI   = 4'd6;
  localparam logic [3:0] POS_H_LO   = 4'd7;
  localparam logic [3:0] POS_DATA   = 4'd8;

  typedef enum logic [1:0] {
    HDR_NONE  = 2'b00,
    HDR_BASIC = 2'b01,
    HDR_SS    = 2'b10
  } hdr_kind_t;

  // one classified input item: optional header plus its data byte
  typedef struct packed {
    hdr_kind_t   hdr;
    logic [7:0]  desc;
    logic [14:0] pic_id;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  data;
    logic        pe;
    logic        fe;
  } frag_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // first byte position for a command
  function automatic logic [3:0] start_pos(hdr_kind_t hdr);
    logic [3:0] p;
    case (hdr)
      HDR_NONE: p = POS_DATA;
      default:  p = POS_DESC;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/vp9pk_queue.sv @@
// command queue between the classifying front and the byte emitting back
module vp9pk_queue
  import vp9pk_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  frag_cmd_t wdata,
  input  logic      rd,
  output frag_cmd_t rdata,
  output q_status_t stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  frag_cmd_t         slots [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  assign rdata      = slots[rd_ptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

endmodule

@@ rtl/vp9pk_front.sv @@
// front part: accepts input items, tracks frame and fragment counts, builds commands
module vp9pk_front
  import vp9pk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [7:0]  data_byte,
  input  logic        frame_begin,
  input  logic [23:0] frame_length,
  input  logic        key_frame,
  input  logic [15:0] pic_width,
  input  logic [15:0] pic_height,
  input  logic        cfg_valid,
  input  logic [13:0] cfg_data,
  input  q_status_t   q_stat,
  output logic        q_wr,
  output frag_cmd_t   q_wdata
);

  logic [13:0] max_frag;
  logic [14:0] next_pic_id;
  logic [14:0] frame_pic_id;
  logic [23:0] bytes_left_frame;
  logic [13:0] bytes_left_packet;
  logic        in_first_packet;
  logic        frame_is_key;

  logic        accept;
  logic        active;
  logic [23:0] blf_cur;
  logic [13:0] blp_cur;
  logic        first_cur;
  logic        key_cur;
  logic [14:0] pic_cur;
  logic        need_hdr;
  logic        with_ss;
  logic [13:0] lim;
  logic [13:0] room;
  logic        fits;
  logic [13:0] chunk;
  logic [13:0] blp_next;
  logic [23:0] blf_next;
  logic [7:0]  desc;

  // effective state for this item, a frame start overrides the stored one
  always_comb begin
    blf_cur   = frame_begin ? ((frame_length == '0) ? 24'd1 : frame_length)
                            : bytes_left_frame;
    blp_cur   = frame_begin ? '0 : bytes_left_packet;
    first_cur = frame_begin | in_first_packet;
    key_cur   = frame_begin ? key_frame : frame_is_key;
    pic_cur   = frame_begin ? next_pic_id : frame_pic_id;
  end

  // fragment sizing
  always_comb begin
    need_hdr = (blp_cur == '0);
    with_ss  = first_cur & key_cur;
    lim      = (max_frag < MIN_FRAG) ? MIN_FRAG : max_frag;
    room     = lim - (with_ss ? HDR_SS_LEN : HDR_BASIC_LEN);
    fits     = (blf_cur <= {10'd0, room});
    chunk    = fits ? blf_cur[13:0] : room;
    blp_next = (need_hdr ? chunk : blp_cur) - 14'd1;
    blf_next = blf_cur - 24'd1;
  end

  // descriptor byte
  always_comb begin
    desc = DESC_I;
    if (!key_cur) desc = desc | DESC_P;
    if (first_cur) desc = desc | DESC_B;
    if (fits) desc = desc | DESC_E;
    if (with_ss) desc = desc | DESC_V;
  end

  assign accept = push & ~q_stat.full;
  assign active = frame_begin | (bytes_left_frame != '0);
  assign q_wr   = accept & active;

  // command for the back part
  always_comb begin
    q_wdata.hdr    = need_hdr ? (with_ss ? HDR_SS : HDR_BASIC) : HDR_NONE;
    q_wdata.desc   = desc;
    q_wdata.pic_id = pic_cur;
    q_wdata.width  = pic_width;
    q_wdata.height = pic_height;
    q_wdata.data   = data_byte;
    q_wdata.pe     = (blp_next == '0);
    q_wdata.fe     = (blf_next == '0);
  end

  // frame and fragment state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frag          <= MAX_FRAG_RESET;
      next_pic_id       <= '0;
      frame_pic_id      <= '0;
      bytes_left_frame  <= '0;
      bytes_left_packet <= '0;
      in_first_packet   <= 1'b0;
      frame_is_key      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_frag <= cfg_data;
      end
      if (q_wr) begin
        if (frame_begin) begin
          next_pic_id  <= next_pic_id + 15'd1;
          frame_pic_id <= next_pic_id;
          frame_is_key <= key_frame;
        end
        bytes_left_frame  <= blf_next;
        bytes_left_packet <= blp_next;
        in_first_packet   <= need_hdr ? 1'b0 : first_cur;
      end
    end
  end

endmodule

@@ rtl/vp9pk_back.sv @@
// back part: walks each command out as its header bytes, if any, followed by the data byte
module vp9pk_back
  import vp9pk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  frag_cmd_t   q_rdata,
  input  q_status_t   q_stat,
  output logic        q_rd,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_byte,
  output logic        packet_end,
  output logic        frame_end,
  output logic        run_end
);

  frag_cmd_t  cur;
  logic       cur_valid;
  logic [3:0] pos;

  logic       last;
  logic       take;
  logic       load;
  logic [3:0] pos_next;

  assign last = (pos == POS_DATA);
  assign take = pop & cur_valid;
  assign load = (~cur_valid | (take & last)) & ~q_stat.empty;
  assign q_rd = load;

  // basic headers skip the scalability structure
  assign pos_next = ((pos == POS_PIC_LO) && (cur.hdr == HDR_BASIC)) ? POS_DATA
                                                                   : pos + 4'd1;

  // position and valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= POS_DATA;
    end else if (load) begin
      cur_valid <= 1'b1;
      pos       <= start_pos(q_rdata.hdr);
    end else if (take) begin
      if (last) begin
        cur_valid <= 1'b0;
      end else begin
        pos <= pos_next;
      end
    end
  end

  // current command
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_rdata;
    end
  end

  // byte select
  always_comb begin
    case (pos)
      POS_DESC:   out_byte = cur.desc;
      POS_PIC_HI: out_byte = PICID_M | {1'b0, cur.pic_id[14:8]};
      POS_PIC_LO: out_byte = cur.pic_id[7:0];
      POS_SS:     out_byte = SS_BYTE0;
      POS_W_HI:   out_byte = cur.width[15:8];
      POS_W_LO:   out_byte = cur.width[7:0];
      POS_H_HI:   out_byte = cur.height[15:8];
      POS_H_LO:   out_byte = cur.height[7:0];
      default:    out_byte = cur.data;
    endcase
  end

  assign empty      = ~cur_valid;
  assign packet_end = last & cur.pe;
  assign frame_end  = last & cur.fe;
  assign run_end    = last;

endmodule

@@ rtl/vp9_rtp_payload_packetizer_unit.sv @@
// top level of the vp9 rtp payload packetizer
// path: an item's command passes through the queue and the back part's current command register
// throughput: one item per cycle while full is low; a fragment start adds 3 header bytes (8 with ss)
// the queue of QUEUE_DEPTH commands absorbs header bursts; full is raised only when it fills
// reset: synchronous active-high rst clears counts, picture id and queue; limit set to 1200
module vp9_rtp_payload_packetizer_unit
  import vp9pk_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        frame_begin,
  input  logic [23:0] frame_length,
  input  logic        key_frame,
  input  logic [15:0] pic_width,
  input  logic [15:0] pic_height,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        packet_end,
  output logic        frame_end,
  output logic        run_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] max_fragment_bytes
);

`include "assert_macros.svh"

  logic      q_wr;
  logic      q_rd;
  frag_cmd_t q_wdata;
  frag_cmd_t q_rdata;
  q_status_t q_stat;

  assign full      = q_stat.full;
  assign cfg_ready = 1'b1;

  // classify items into commands
  vp9pk_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .data_byte    (data_byte),
    .frame_begin  (frame_begin),
    .frame_length (frame_length),
    .key_frame    (key_frame),
    .pic_width    (pic_width),
    .pic_height   (pic_height),
    .cfg_valid    (cfg_valid),
    .cfg_data     (max_fragment_bytes),
    .q_stat       (q_stat),
    .q_wr         (q_wr),
    .q_wdata      (q_wdata)
  );

  // command queue
  vp9pk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // emit bytes
  vp9pk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_rdata    (q_rdata),
    .q_stat     (q_stat),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .packet_end (packet_end),
    .frame_end  (frame_end),
    .run_end    (run_end)
  );

  // checks
  `ASSERT_ALWAYS(a_hdr_no_end, empty || run_end || !(packet_end || frame_end), "hdr end flag")
  `ASSERT_ALWAYS(a_frame_end_pkt, empty || !frame_end || packet_end, "frame end w/o pkt end")
  `ASSERT_NEXT(a_begin_kept, push && !full && frame_begin, !q_stat.empty || !empty, "item lost")
  `ASSERT_ALWAYS(a_queue_sane, !(q_stat.full && q_stat.empty), "queue full and empty")

endmodule

@@ bench/vp9_rtp_payload_packetizer_unit_checker.sv @@
// checker that predicts the packetizer byte stream and compares it with the block
`timescale 1ns / 100ps
module vp9_rtp_payload_packetizer_unit_checker
  import vp9pk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte,
  input  logic        frame_begin,
  input  logic [23:0] frame_length,
  input  logic        key_frame,
  input  logic [15:0] pic_width,
  input  logic [15:0] pic_height,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        packet_end,
  input  logic        frame_end,
  input  logic        run_end,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [13:0] max_fragment_bytes,
  output int          errors,
  output int          pending,
  output int          bytes_in,
  output int          bytes_out
);

  // one byte of a fragment with its end marks
  typedef struct packed {
    logic [7:0] value;
    logic       pkt_last;
    logic       frm_last;
    logic       run_last;
  } frag_byte_t;

  frag_byte_t frag_bytes_due[$];

  // packetizer state as the block should hold it
  logic [13:0] frag_limit;
  logic [14:0] pic_id_next;
  logic [14:0] pic_id_cur;
  logic [23:0] frame_left;
  logic [13:0] frag_left;
  logic        first_frag;
  logic        key_cur;

  task automatic add_due(input logic [7:0] v, input logic pe, input logic fe,
                         input logic re);
    frag_byte_t fb;
    fb = '{v, pe, fe, re};
    frag_bytes_due = {frag_bytes_due, fb};
  endtask

  // works out every output byte that one input item causes
  task automatic packetize_byte(input logic [7:0] d, input logic b,
                                input logic [23:0] len, input logic key,
                                input logic [15:0] w, input logic [15:0] h);
    logic        with_ss;
    logic [13:0] lim;
    logic [13:0] room;
    logic [23:0] chunk;
    logic [7:0]  desc;
    if (b) begin
      pic_id_cur  = pic_id_next;
      pic_id_next = pic_id_next + 15'd1;
      key_cur     = key;
      frame_left  = (len == 24'd0) ? 24'd1 : len;
      frag_left   = '0;
      first_frag  = 1'b1;
    end else if (frame_left == 24'd0) begin
      // stray byte with no frame open
      return;
    end
    // fragment start: descriptor, picture id, maybe scalability structure
    if (frag_left == 14'd0) begin
      with_ss = first_frag & key_cur;
      lim     = (frag_limit < MIN_FRAG) ? MIN_FRAG : frag_limit;
      room    = lim - (with_ss ? HDR_SS_LEN : HDR_BASIC_LEN);
      chunk   = (frame_left < {10'd0, room}) ? frame_left : {10'd0, room};
      desc    = DESC_I;
      if (!key_cur) desc = desc | DESC_P;
      if (first_frag) desc = desc | DESC_B;
      if (chunk == frame_left) desc = desc | DESC_E;
      if (with_ss) desc = desc | DESC_V;
      add_due(desc, 1'b0, 1'b0, 1'b0);
      add_due(PICID_M | {1'b0, pic_id_cur[14:8]}, 1'b0, 1'b0, 1'b0);
      add_due(pic_id_cur[7:0], 1'b0, 1'b0, 1'b0);
      if (with_ss) begin
        add_due(SS_BYTE0, 1'b0, 1'b0, 1'b0);
        add_due(w[15:8], 1'b0, 1'b0, 1'b0);
        add_due(w[7:0], 1'b0, 1'b0, 1'b0);
        add_due(h[15:8], 1'b0, 1'b0, 1'b0);
        add_due(h[7:0], 1'b0, 1'b0, 1'b0);
      end
      frag_left  = chunk[13:0];
      first_frag = 1'b0;
    end
    frag_left  = frag_left - 14'd1;
    frame_left = frame_left - 24'd1;
    add_due(d, frag_left == 14'd0, frame_left == 24'd0, 1'b1);
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin
    frag_byte_t want;
    frag_byte_t got;
    if (rst) begin
      frag_bytes_due.delete();
      frag_limit  = MAX_FRAG_RESET;
      pic_id_next = '0;
      pic_id_cur  = '0;
      frame_left  = '0;
      frag_left   = '0;
      first_frag  = 1'b0;
      key_cur     = 1'b0;
      errors      <= 0;
      bytes_in    <= 0;
      bytes_out   <= 0;
    end else begin
      if (push && !full) begin
        bytes_in <= bytes_in + 1;
        packetize_byte(data_byte, frame_begin, frame_length, key_frame,
                       pic_width, pic_height);
      end
      // a limit written at this edge applies to later items
      if (cfg_valid && cfg_ready) frag_limit = max_fragment_bytes;
      if (pop && !empty) begin
        got = '{out_byte, packet_end, frame_end, run_end};
        bytes_out <= bytes_out + 1;
        if (frag_bytes_due.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected item: byte %02h pe %b fe %b re %b",
                     $realtime, got.value, got.pkt_last, got.frm_last, got.run_last);
          errors <= errors + 1;
        end else begin
          want = frag_bytes_due.pop_front();
          if (got.value !== want.value || got.pkt_last !== want.pkt_last ||
              got.frm_last !== want.frm_last || got.run_last !== want.run_last) begin
            if (errors < 10)
              $display(
                "%0t: item %0d: expected %02h pe %b fe %b re %b, got %02h pe %b fe %b re %b",
                $realtime, bytes_out, want.value, want.pkt_last, want.frm_last,
                want.run_last, got.value, got.pkt_last, got.frm_last, got.run_last);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= frag_bytes_due.size();
  end

endmodule

@@ bench/vp9_rtp_payload_packetizer_unit_tb.sv @@
// testbench top: drives the vp9 packetizer with frames and gives the verdict
`timescale 1ns / 100ps
module vp9_rtp_payload_packetizer_unit_tb;
  import vp9pk_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = '0;
  logic        frame_begin = 1'b0;
  logic [23:0] frame_length = '0;
  logic        key_frame = 1'b0;
  logic [15:0] pic_width = '0;
  logic [15:0] pic_height = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        packet_end;
  logic        frame_end;
  logic        run_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [13:0] max_fragment_bytes = '0;

  int errors;
  int pending;
  int bytes_in;
  int bytes_out;

  bit steady = 1'b0;
  bit rx_hold_request = 1'b0;
  int frames_sent = 0;
  int frames_cut = 0;

  vp9_rtp_payload_packetizer_unit dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .data_byte(data_byte), .frame_begin(frame_begin), .frame_length(frame_length),
    .key_frame(key_frame), .pic_width(pic_width), .pic_height(pic_height),
    .empty(empty), .pop(pop),
    .out_byte(out_byte), .packet_end(packet_end), .frame_end(frame_end),
    .run_end(run_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .max_fragment_bytes(max_fragment_bytes)
  );

  vp9_rtp_payload_packetizer_unit_checker u_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .data_byte(data_byte), .frame_begin(frame_begin), .frame_length(frame_length),
    .key_frame(key_frame), .pic_width(pic_width), .pic_height(pic_height),
    .empty(empty), .pop(pop),
    .out_byte(out_byte), .packet_end(packet_end), .frame_end(frame_end),
    .run_end(run_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .max_fragment_bytes(max_fragment_bytes),
    .errors(errors), .pending(pending), .bytes_in(bytes_in), .bytes_out(bytes_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard limit on run time
  initial begin
    #20_000_000;
    $display("vp9_rtp_payload_packetizer_unit_tb: FAIL");
    $finish;
  end

  // receiver: random pops, a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_request) begin
        rx_hold_request = 1'b0;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= steady || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  // offer one input item, with random idle cycles ahead of it unless steady is set
  task automatic offer_byte(input logic [7:0] d, input logic b, input logic [23:0] len,
                            input logic key, input logic [15:0] w, input logic [15:0] h);
    while (!steady && $urandom_range(0, 99) < 31) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    data_byte    <= d;
    frame_begin  <= b;
    frame_length <= len;
    key_frame    <= key;
    pic_width    <= w;
    pic_height   <= h;
    do @(posedge clk); while (full);
  endtask

  // stray byte; ignored when no frame is open
  task automatic send_stray();
    offer_byte(8'($urandom), 1'b0, 24'($urandom), 1'($urandom), 16'($urandom),
               16'($urandom));
  endtask

  // frame start with the given length field, then nbytes-1 more bytes
  task automatic send_frame(input logic [23:0] len, input int nbytes, input logic key,
                            input logic [15:0] w, input logic [15:0] h);
    offer_byte(8'($urandom), 1'b1, len, key, w, h);
    for (int i = 1; i < nbytes; i++) send_stray();
    frames_sent++;
  endtask

  // stop sending until every expected item is out, then let the pipe settle
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_frag_limit(input logic [13:0] v);
    drain();
    cfg_valid          <= 1'b1;
    max_fragment_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly whole frames, some cut short, zero-length and stray bytes
  task automatic random_phase(input int n_items);
    int          done_items;
    int          pick;
    int          n;
    logic [23:0] len;
    done_items = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        n = $urandom_range(1, 40);
        send_frame(24'(n), n, $urandom_range(0, 99) < 30, 16'($urandom), 16'($urandom));
      end else if (pick < 88) begin
        n   = $urandom_range(1, 8);
        len = 24'($urandom);
        if (len <= n) len = 24'(n + 1);
        send_frame(len, n, 1'($urandom), 16'($urandom), 16'($urandom));
        frames_cut++;
      end else if (pick < 94) begin
        n = 1;
        send_frame(24'd0, 1, 1'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        n = 0;
        repeat ($urandom_range(1, 3)) send_stray();
      end
      done_items += n;
    end
    // close any frame left open
    send_frame(24'd1, 1, 1'b0, 16'($urandom), 16'($urandom));
  endtask

  // stimulus
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset limit
    send_stray();
    send_frame(24'd1, 1, 1'b0, 16'h0000, 16'h0000);
    send_frame(24'd1, 1, 1'b1, 16'hFFFF, 16'h0000);
    send_frame(24'd0, 1, 1'b1, 16'h0000, 16'hFFFF);
    send_frame(24'd3, 3, 1'b0, 16'($urandom), 16'($urandom));
    // long frame abandoned by an early start
    send_frame(24'hFFFFFF, 3, 1'b1, 16'($urandom), 16'($urandom));
    frames_cut++;
    send_frame(24'd2, 2, 1'b0, 16'($urandom), 16'($urandom));
    send_stray();
    // limit below the minimum, then at it
    set_frag_limit(14'd0);
    send_frame(24'd5, 5, 1'b1, 16'($urandom), 16'($urandom));
    set_frag_limit(MIN_FRAG);
    send_frame(24'd7, 7, 1'b0, 16'($urandom), 16'($urandom));

    // random part; first phase stalls the receiver long enough to fill the block
    set_frag_limit(14'h3FFF);
    rx_hold_request = 1'b1;
    random_phase(50);
    set_frag_limit(14'd10);
    steady = 1'b1;
    random_phase(50);
    steady = 1'b0;
    set_frag_limit(14'd13);
    random_phase(50);
    set_frag_limit(14'd5);
    random_phase(40);
    set_frag_limit(14'($urandom_range(9, 40)));
    random_phase(50);
    set_frag_limit(14'($urandom_range(0, 16383)));
    random_phase(50);

    drain();
    $display("run covered %0d frames (%0d cut short), %0d input items, %0d output items",
             frames_sent, frames_cut, bytes_in, bytes_out);
    $display("fragment limits from below the minimum to the maximum, zero-length frames");
    if (errors == 0 && pending == 0) begin
      $display("vp9_rtp_payload_packetizer_unit_tb: PASS");
    end else begin
      $display("vp9_rtp_payload_packetizer_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ vp9_rtp_payload_packetizer_unit.f @@
+incdir+rtl
rtl/vp9pk_pkg.sv
rtl/vp9pk_queue.sv
rtl/vp9pk_front.sv
rtl/vp9pk_back.sv
rtl/vp9_rtp_payload_packetizer_unit.sv
bench/vp9_rtp_payload_packetizer_unit_checker.sv
bench/vp9_rtp_payload_packetizer_unit_tb.sv
